// ----- rtl/lzss_decompressor_top_defines.svh -----
// assertion macros used by the checker file
`ifndef LZSS_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZSS_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LZD_ASSERT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LZD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/lzd_pkg.sv -----
// shared types and constants for the lzss decompressor
package lzd_pkg;

  localparam int unsigned WIN_AW    = 12;
  localparam int unsigned WIN_DEPTH = 4096;
  localparam logic [WIN_AW-1:0] WIN_START = 12'd4078;
  localparam int unsigned LEN_W     = 5;
  localparam logic [LEN_W-1:0] MATCH_MIN_LEN = 5'd3;

  // compressed stream transaction
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  // decompressed byte transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // stream decode phase
  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_TOKEN    = 2'd1,
    PH_MATCH_HI = 2'd2
  } dec_phase_t;

  // sequencer state
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_MATCH_RD = 2'd1,
    ST_MATCH_WR = 2'd2
  } ctl_state_t;

  // window control from sequencer
  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } win_ctrl_t;

endpackage

// ----- rtl/lzd_window.sv -----
// history window memory with fill count for stream-start zero contents
module lzd_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lzd_pkg::win_ctrl_t        ctrl,
  input  logic [7:0]                wr_data,
  input  logic [lzd_pkg::WIN_AW-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import lzd_pkg::*;

  logic [7:0]        mem [WIN_DEPTH];
  logic [WIN_AW-1:0] wpos_r, wpos_nxt;
  logic [WIN_AW:0]   fill_r, fill_nxt;
  logic [7:0]        rd_q_r;
  logic              rd_ok_r, rd_ok_nxt;
  logic [WIN_AW-1:0] rd_ofs;

  // write pointer and count of bytes written since stream start
  always_comb begin
    wpos_nxt = wpos_r;
    fill_nxt = fill_r;
    if (ctrl.clear) begin
      wpos_nxt = WIN_START;
      fill_nxt = '0;
    end else if (ctrl.wr_en) begin
      wpos_nxt = wpos_r + 1'b1;
      if (fill_r != (WIN_AW+1)'(WIN_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  // entries are written contiguously from the start position
  assign rd_ofs    = rd_addr - WIN_START;
  assign rd_ok_nxt = ({1'b0, rd_ofs} < fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r  <= WIN_START;
      fill_r  <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      wpos_r <= wpos_nxt;
      fill_r <= fill_nxt;
      if (ctrl.rd_en) begin
        rd_ok_r <= rd_ok_nxt;
      end
    end
  end

  // memory array
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wpos_r] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // unwritten entries read as zero
  assign rd_data = rd_ok_r ? rd_q_r : 8'h00;

endmodule

// ----- rtl/lzss_decompressor_top.sv -----
// lzss decompressor top level: stream decoder, match sequencer, output register
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------
//   in_      | in_valid / in_ready  | in_data  (in_byte, end_of_stream)
//   out_     | out_valid / out_ready| out_data (out_byte, run_last)
//   cfg_     | cfg_wr_en            | cfg_wr_data (out_capacity)
//
// header, flag and match-low bytes and literals are taken while idle. a match high byte
// starts the copy of 3 to 18 bytes, each a window read, then a write-back that waits
// for a free output register, because of the single window port and its read latency.
// synchronous active-low reset; window contents need no clearing pass.
// a stalled output holds the sequencer and blocks new input transactions.
module lzss_decompressor_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lzd_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  import lzd_pkg::*;

  ctl_state_t        state_r, state_nxt;
  dec_phase_t        phase_r, phase_nxt;
  logic [8:0]        flag_r, flag_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [1:0]        hdr_cnt_r, hdr_cnt_nxt;
  logic [23:0]       size_r, size_nxt;
  logic              rej_r, rej_nxt;
  logic [31:0]       cap_r;
  logic [WIN_AW-1:0] src_r, src_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic              eos_hold_r, eos_hold_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic       accept;
  logic       out_free;
  logic       is_literal;
  logic       is_match_hi;
  logic       last_copy;
  logic [31:0] full_size;
  win_ctrl_t  win_ctrl;
  logic [7:0] win_wr_data;
  logic [7:0] win_rd_data;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // token decode of the accepted byte
  assign is_literal  = accept && !rej_r && (phase_r == PH_TOKEN) &&
                       (flag_r[8:1] != 8'h00) && flag_r[0];
  assign is_match_hi = accept && !rej_r && (phase_r == PH_MATCH_HI);
  assign last_copy   = (remain_r == LEN_W'(1));
  assign full_size   = {in_data.in_byte, size_r};

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_match_hi) begin
          state_nxt = ST_MATCH_RD;
        end
      end
      ST_MATCH_RD: begin
        state_nxt = ST_MATCH_WR;
      end
      ST_MATCH_WR: begin
        if (out_free) begin
          state_nxt = last_copy ? ST_IDLE : ST_MATCH_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // decode, window control and output register loading
  always_comb begin
    phase_nxt     = phase_r;
    flag_nxt      = flag_r;
    lo_nxt        = lo_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    size_nxt      = size_r;
    rej_nxt       = rej_r;
    src_nxt       = src_r;
    remain_nxt    = remain_r;
    eos_hold_nxt  = eos_hold_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    win_ctrl      = '0;
    win_wr_data   = in_data.in_byte;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && !rej_r) begin
          unique case (phase_r)
            PH_HEADER: begin
              hdr_cnt_nxt = hdr_cnt_r + 1'b1;
              unique case (hdr_cnt_r)
                2'd0: size_nxt[7:0]   = in_data.in_byte;
                2'd1: size_nxt[15:8]  = in_data.in_byte;
                2'd2: size_nxt[23:16] = in_data.in_byte;
                default: begin
                  rej_nxt   = (cap_r == 32'h0) || (full_size > cap_r);
                  phase_nxt = PH_TOKEN;
                end
              endcase
            end
            PH_TOKEN: begin
              if (flag_r[8:1] == 8'h00) begin
                flag_nxt = {1'b1, in_data.in_byte};
              end else if (flag_r[0]) begin
                flag_nxt       = flag_r >> 1;
                win_ctrl.wr_en = 1'b1;
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '{out_byte: in_data.in_byte, run_last: 1'b1};
              end else begin
                lo_nxt    = in_data.in_byte;
                phase_nxt = PH_MATCH_HI;
              end
            end
            PH_MATCH_HI: begin
              src_nxt      = {in_data.in_byte[7:4], lo_r};
              remain_nxt   = {1'b0, in_data.in_byte[3:0]} + MATCH_MIN_LEN;
              eos_hold_nxt = in_data.end_of_stream;
              flag_nxt     = flag_r >> 1;
              phase_nxt    = PH_TOKEN;
            end
            default: begin
              phase_nxt = PH_HEADER;
            end
          endcase
        end
      end
      ST_MATCH_RD: begin
        win_ctrl.rd_en = 1'b1;
      end
      ST_MATCH_WR: begin
        win_wr_data = win_rd_data;
        if (out_free) begin
          win_ctrl.wr_en = 1'b1;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '{out_byte: win_rd_data, run_last: last_copy};
          src_nxt        = src_r + 1'b1;
          remain_nxt     = remain_r - 1'b1;
        end
      end
      default: begin
      end
    endcase

    // stream end: back to stream-start state after the last output
    if ((accept && in_data.end_of_stream && !is_match_hi) ||
        ((state_r == ST_MATCH_WR) && out_free && last_copy && eos_hold_r)) begin
      phase_nxt      = PH_HEADER;
      flag_nxt       = '0;
      lo_nxt         = '0;
      hdr_cnt_nxt    = '0;
      size_nxt       = '0;
      rej_nxt        = 1'b0;
      win_ctrl.clear = 1'b1;
    end
  end

  // control and stream state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_HEADER;
      flag_r      <= '0;
      lo_r        <= '0;
      hdr_cnt_r   <= '0;
      size_r      <= '0;
      rej_r       <= 1'b0;
      cap_r       <= '0;
      remain_r    <= '0;
      eos_hold_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flag_r      <= flag_nxt;
      lo_r        <= lo_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      size_r      <= size_nxt;
      rej_r       <= rej_nxt;
      remain_r    <= remain_nxt;
      eos_hold_r  <= eos_hold_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    out_data_r <= out_data_nxt;
  end

  lzd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (win_ctrl),
    .wr_data (win_wr_data),
    .rd_addr (src_r),
    .rd_data (win_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/lzd_checker.sv -----
// port-level checker for the lzss decompressor and its bind
`include "lzss_decompressor_top_defines.svh"

module lzd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lzd_pkg::out_item_t out_data
);
  import lzd_pkg::*;

  // a pending result holds until taken
  `LZD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped while stalled")

  // a stalled result keeps its payload
  `LZD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "output changed while stalled")

  // no new input transaction while the output side is stalled
  `LZD_ASSERT(a_in_blocked, in_ready, !out_valid || out_ready, "input taken over a stalled result")

  // a run of match bytes completes before the next input transaction
  `LZD_ASSERT(a_run_complete, out_valid && out_ready && !out_data.run_last, !in_ready, "input taken inside a run")

endmodule

bind lzss_decompressor_top lzd_checker u_lzd_checker (.*);
